FILE: rtl/core/decimal_number_text_parser_macros.svh
// Assertion macros for the decimal number text parser.
`ifndef DECIMAL_NUMBER_TEXT_PARSER_MACROS_SVH
`define DECIMAL_NUMBER_TEXT_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define DNP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnp: same-cycle check failed");
`define DNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnp: next-cycle check failed");
`else
`define DNP_ASSERT_NOW(label, clk, rst, ante, cons)
`define DNP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/dnp_pkg.sv
// Shared constants, types and functions of the decimal number text parser.
package dnp_pkg;

   localparam int FRAC_BITS_DEF = 48;
   localparam int INT_W         = 32;
   localparam int OUT_FRAC_W    = 32;
   localparam int CHAR_W        = 8;
   localparam int DIGIT_W       = 4;
   localparam int DEC_BASE      = 10;
   // Place weights reach zero after at most 19 fraction digits at 60 bits.
   localparam int WEIGHT_DEPTH  = 20;
   localparam int WIDX_W        = $clog2(WEIGHT_DEPTH);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_F     = 8'h66;

   localparam logic [2:0] KIND_DIGIT = 3'd0;
   localparam logic [2:0] KIND_DOT   = 3'd1;
   localparam logic [2:0] KIND_PLUS  = 3'd2;
   localparam logic [2:0] KIND_MINUS = 3'd3;
   localparam logic [2:0] KIND_F     = 3'd4;
   localparam logic [2:0] KIND_OTHER = 3'd5;

   typedef struct packed {
      logic [2:0]         kind;
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } dnp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dnp_q_status_type;

   // floor(2^frac_bits / 10^(k+1)), evaluated at elaboration only.
   function automatic logic [63:0] place_weight(input int frac_bits, input int k);
      logic [63:0] w;
      w = 64'd1 << frac_bits;
      for (int i = 0; i <= k; i++) begin
         w = w / DEC_BASE;
      end
      return w;
   endfunction

endpackage

FILE: rtl/core/dnp_channels_if.sv
// Channel interfaces of the decimal number text parser.
interface dnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;
   modport source (output valid, char_code, last, input ready);
   modport sink (input valid, char_code, last, output ready);
endinterface

interface dnp_rsp_if;
   logic               valid;
   logic               ready;
   logic               valid_res;
   logic signed [31:0] int_value;
   logic        [31:0] frac_value;
   logic               negative;
   modport source (output valid, valid_res, int_value, frac_value, negative, input ready);
   modport sink (input valid, valid_res, int_value, frac_value, negative, output ready);
endinterface

interface dnp_csr_if;
   logic valid;
   logic ready;
   logic fraction_enable;
   modport source (output valid, fraction_enable, input ready);
   modport sink (input valid, fraction_enable, output ready);
endinterface

FILE: rtl/core/dnp_front.sv
// Front end: accepts characters and classifies them for the queue.
module dnp_front
   import dnp_pkg::*;
(
   dnp_req_if.sink          req_if,
   input  dnp_q_status_type q_status,
   output logic             push_valid,
   output dnp_item_type     push_item
);

   logic [CHAR_W-1:0] code;
   logic [CHAR_W-1:0] offset;

   assign code   = req_if.char_code;
   assign offset = code - CHAR_ZERO;

   assign req_if.ready = !q_status.full;
   assign push_valid   = req_if.valid && !q_status.full;

   always_comb begin
      push_item.last  = req_if.last;
      push_item.digit = offset[DIGIT_W-1:0];
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         push_item.kind = KIND_DIGIT;
      end else if (code == CHAR_DOT) begin
         push_item.kind = KIND_DOT;
      end else if (code == CHAR_PLUS) begin
         push_item.kind = KIND_PLUS;
      end else if (code == CHAR_MINUS) begin
         push_item.kind = KIND_MINUS;
      end else if (code == CHAR_F) begin
         push_item.kind = KIND_F;
      end else begin
         push_item.kind = KIND_OTHER;
      end
   end

endmodule

FILE: rtl/core/dnp_queue.sv
// Short queue of classified characters between front end and back end.
module dnp_queue
   import dnp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  dnp_item_type     push_item,
   input  logic             pop,
   output dnp_q_status_type q_status,
   output dnp_item_type     pop_item
);

   dnp_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/core/dnp_back.sv
// Back end: runs the string state per character and registers the result.
module dnp_back
   import dnp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fraction_enable,
   input  logic         item_valid,
   input  dnp_item_type item,
   output logic         item_pop,
   dnp_rsp_if.source    rsp_if
);

   logic [FRAC_BITS-1:0] weight_tab [WEIGHT_DEPTH];

   for (genvar k = 0; k < WEIGHT_DEPTH; k++) begin : g_weight
      assign weight_tab[k] = FRAC_BITS'(place_weight(FRAC_BITS, k));
   end

   logic [INT_W-1:0]      int_accum_ff, int_accum_in;
   logic [FRAC_BITS-1:0]  frac_accum_ff, frac_accum_in;
   logic [WIDX_W-1:0]     widx_ff, widx_in;
   logic                  first_char_ff, first_char_in;
   logic                  seen_dot_ff, seen_dot_in;
   logic                  seen_minus_ff, seen_minus_in;
   logic                  seen_f_ff, seen_f_in;
   logic                  seen_digit_ff, seen_digit_in;
   logic                  error_ff, error_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  valid_res_ff, valid_res_in;
   logic [INT_W-1:0]      int_value_ff, int_value_in;
   logic [OUT_FRAC_W-1:0] frac_value_ff, frac_value_in;
   logic                  negative_ff, negative_in;

   logic                  out_free;
   logic                  finish;
   logic                  ok;
   logic [FRAC_BITS+DIGIT_W-1:0] prod;
   logic [INT_W-1:0]      int_step;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign item_pop = item_valid && (!item.last || out_free);
   assign finish   = item_pop && item.last;

   assign prod     = (FRAC_BITS+DIGIT_W)'(weight_tab[widx_ff])
                   * (FRAC_BITS+DIGIT_W)'(item.digit);
   assign int_step = (int_accum_ff << 3) + (int_accum_ff << 1)
                   + INT_W'(item.digit);

   // Next string state after this character.
   always_comb begin
      int_accum_in  = int_accum_ff;
      frac_accum_in = frac_accum_ff;
      widx_in       = widx_ff;
      seen_dot_in   = seen_dot_ff;
      seen_minus_in = seen_minus_ff;
      seen_f_in     = seen_f_ff;
      seen_digit_in = seen_digit_ff;
      error_in      = error_ff;
      first_char_in = 1'b0;
      if (seen_f_ff) begin
         error_in = 1'b1;
      end else begin
         case (item.kind)
            KIND_DIGIT: begin
               seen_digit_in = 1'b1;
               if (seen_dot_ff) begin
                  frac_accum_in = frac_accum_ff + prod[FRAC_BITS-1:0];
                  if (widx_ff != WIDX_W'(WEIGHT_DEPTH-1)) begin
                     widx_in = widx_ff + WIDX_W'(1);
                  end
               end else begin
                  int_accum_in = int_step;
               end
            end
            KIND_DOT: begin
               if (seen_dot_ff) begin
                  error_in = 1'b1;
               end
               seen_dot_in = 1'b1;
            end
            KIND_PLUS: begin
               if (!first_char_ff) begin
                  error_in = 1'b1;
               end
            end
            KIND_MINUS: begin
               if (!first_char_ff) begin
                  error_in = 1'b1;
               end
               seen_minus_in = 1'b1;
            end
            KIND_F: begin
               seen_f_in = 1'b1;
            end
            default: begin
               error_in = 1'b1;
            end
         endcase
      end
   end

   assign ok = !error_in && seen_digit_in;

   always_comb begin
      valid_res_in  = ok;
      negative_in   = ok && seen_minus_in;
      int_value_in  = '0;
      frac_value_in = '0;
      if (ok) begin
         int_value_in = seen_minus_in ? INT_W'(0) - int_accum_in : int_accum_in;
         if (fraction_enable) begin
            frac_value_in = frac_accum_in[FRAC_BITS-1 -: OUT_FRAC_W];
         end
      end
      rsp_valid_in = finish ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_accum_ff  <= '0;
         frac_accum_ff <= '0;
         widx_ff       <= '0;
         first_char_ff <= 1'b1;
         seen_dot_ff   <= 1'b0;
         seen_minus_ff <= 1'b0;
         seen_f_ff     <= 1'b0;
         seen_digit_ff <= 1'b0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            // Drop the string state once the last character is done.
            int_accum_ff  <= '0;
            frac_accum_ff <= '0;
            widx_ff       <= '0;
            first_char_ff <= 1'b1;
            seen_dot_ff   <= 1'b0;
            seen_minus_ff <= 1'b0;
            seen_f_ff     <= 1'b0;
            seen_digit_ff <= 1'b0;
            error_ff      <= 1'b0;
         end else if (item_pop) begin
            int_accum_ff  <= int_accum_in;
            frac_accum_ff <= frac_accum_in;
            widx_ff       <= widx_in;
            first_char_ff <= first_char_in;
            seen_dot_ff   <= seen_dot_in;
            seen_minus_ff <= seen_minus_in;
            seen_f_ff     <= seen_f_in;
            seen_digit_ff <= seen_digit_in;
            error_ff      <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         valid_res_ff  <= valid_res_in;
         int_value_ff  <= int_value_in;
         frac_value_ff <= frac_value_in;
         negative_ff   <= negative_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.valid_res  = valid_res_ff;
   assign rsp_if.int_value  = int_value_ff;
   assign rsp_if.frac_value = frac_value_ff;
   assign rsp_if.negative   = negative_ff;

endmodule

FILE: rtl/core/decimal_number_text_parser.sv
// Top level of the decimal number text parser.
// Takes one character per cycle on req_if, with last set on the final character of a
// string, and returns one result per string on rsp_if: a valid flag, the signed integer
// part, the fraction as unsigned Q0.32 and the minus flag. A character is accepted
// every cycle while the four-entry character queue has room; the back end retires one
// character per cycle from that queue unless stalled, so throughput is one character per
// cycle; a string's result is registered when its last character leaves the queue. A
// result waiting in the output register stalls only the back end on a last character;
// the queue keeps taking characters meanwhile. csr_if writes fraction_enable (reset 1)
// and is always ready; write it only while no string is in flight.
`include "decimal_number_text_parser_macros.svh"

module decimal_number_text_parser
   import dnp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dnp_req_if.sink   req_if,
   dnp_rsp_if.source rsp_if,
   dnp_csr_if.sink   csr_if
);

   logic             fraction_enable_ff, fraction_enable_in;
   logic             push_valid;
   dnp_item_type     push_item;
   dnp_item_type     q_item;
   dnp_q_status_type q_status;
   logic             q_pop;

   assign csr_if.ready       = 1'b1;
   assign fraction_enable_in = csr_if.valid ? csr_if.fraction_enable : fraction_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_enable_ff <= 1'b1;
      end else begin
         fraction_enable_ff <= fraction_enable_in;
      end
   end

   dnp_front u_front (
      .req_if     (req_if),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   dnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (q_pop),
      .q_status   (q_status),
      .pop_item   (q_item)
   );

   dnp_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .fraction_enable (fraction_enable_ff),
      .item_valid      (!q_status.empty),
      .item            (q_item),
      .item_pop        (q_pop),
      .rsp_if          (rsp_if)
   );

   `DNP_ASSERT_NOW(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)
   `DNP_ASSERT_NEXT(a_last_gives_rsp, clock, reset, q_pop && q_item.last, rsp_if.valid)
   `DNP_ASSERT_NOW(a_bad_is_zero, clock, reset, rsp_if.valid && !rsp_if.valid_res, rsp_if.int_value == 0 && rsp_if.frac_value == 0 && !rsp_if.negative)

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the decimal number text parser, with its own parser prediction.
module testbench;
   import dnp_pkg::*;

   localparam int FB              = FRAC_BITS_DEF;
   localparam int GAP_MAX         = 12;
   localparam int SETTLE_CYCLES   = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int MAX_REPORTS     = 40;
   localparam logic [FB-1:0] WEIGHT_START = FB'((64'd1 << FB) / DEC_BASE);

   typedef logic [CHAR_W-1:0] char_type;
   typedef char_type text_type[$];

   typedef struct packed {
      logic                     valid_res;
      logic signed [INT_W-1:0]  int_value;
      logic [OUT_FRAC_W-1:0]    frac_value;
      logic                     negative;
   } number_type;

   localparam char_type MARKS [4] = '{CHAR_DOT, CHAR_PLUS, CHAR_MINUS, CHAR_F};

   logic clock = 1'b0;
   logic reset;

   dnp_req_if req_ch();
   dnp_rsp_if rsp_ch();
   dnp_csr_if csr_ch();

   decimal_number_text_parser uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   number_type pending_numbers[$];
   int      error_count     = 0;
   int      items_sent      = 0;
   int      idle_cycles     = 0;
   int      hold_off_cycles = 0;
   bit      steady_send     = 1'b0;
   bit      steady_recv     = 1'b0;

   // shadow of the parser state
   logic [INT_W-1:0] int_acc;
   logic [FB-1:0]    frac_acc;
   logic [FB-1:0]    place_w;
   bit               frac_on;
   bit               at_start;
   bit               seen_dot;
   bit               seen_minus;
   bit               seen_f;
   bit               seen_digit;
   bit               malformed;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic clear_number();
      int_acc    = '0;
      frac_acc   = '0;
      place_w    = WEIGHT_START;
      at_start   = 1'b1;
      seen_dot   = 1'b0;
      seen_minus = 1'b0;
      seen_f     = 1'b0;
      seen_digit = 1'b0;
      malformed  = 1'b0;
   endtask

   task automatic predict_char(input char_type c, input bit is_last);
      number_type    n;
      logic [63:0]   q32;
      logic [FB-1:0] d;
      d = FB'(c - CHAR_ZERO);
      if (seen_f) begin
         malformed = 1'b1;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         seen_digit = 1'b1;
         if (seen_dot) begin
            frac_acc = frac_acc + d * place_w;
            place_w  = place_w / DEC_BASE;
         end else begin
            int_acc = int_acc * DEC_BASE + INT_W'(d);
         end
      end else if (c == CHAR_DOT) begin
         if (seen_dot) malformed = 1'b1;
         seen_dot = 1'b1;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         if (!at_start) malformed = 1'b1;
         if (c == CHAR_MINUS) seen_minus = 1'b1;
      end else if (c == CHAR_F) begin
         seen_f = 1'b1;
      end else begin
         malformed = 1'b1;
      end
      at_start = 1'b0;
      if (is_last) begin
         n = '0;
         if (!malformed && seen_digit) begin
            q32          = 64'(frac_acc) >> (FB - OUT_FRAC_W);
            n.valid_res  = 1'b1;
            n.int_value  = seen_minus ? -int_acc : int_acc;
            n.frac_value = !frac_on ? '0 : (q32 > 64'hFFFF_FFFF) ? '1 : q32[OUT_FRAC_W-1:0];
            n.negative   = seen_minus;
         end
         pending_numbers.push_back(n);
         clear_number();
      end
   endtask

   task automatic send_char(input char_type c, input bit is_last);
      int gap;
      gap = steady_send ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      req_ch.last      <= is_last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_char(c, is_last);
      items_sent++;
   endtask

   task automatic send_text(input text_type s);
      foreach (s[i]) send_char(s[i], i == s.size() - 1);
   endtask

   // drop valid, then hold until every string has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fraction_enable(input bit value);
      @(negedge clock);
      csr_ch.valid           <= 1'b1;
      csr_ch.fraction_enable <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      frac_on = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic char_type digit_char(input int d);
      return CHAR_ZERO + char_type'(d);
   endfunction

   function automatic text_type make_number();
      text_type s;
      int    n_int;
      int    n_frac;
      bit    has_dot;
      case ($urandom_range(0, 2))
         1: s.push_back(CHAR_PLUS);
         2: s.push_back(CHAR_MINUS);
         default: ;
      endcase
      has_dot = 1'($urandom_range(0, 1));
      n_int   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 4);
      n_frac  = !has_dot ? 0 :
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 4);
      if (n_int + n_frac == 0) begin
         if (has_dot) n_frac = 1;
         else n_int = 1;
      end
      repeat (n_int) s.push_back(digit_char($urandom_range(0, 9)));
      if (has_dot) s.push_back(CHAR_DOT);
      repeat (n_frac) s.push_back(digit_char($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) s.push_back(CHAR_F);
      return s;
   endfunction

   // mostly well-formed numbers, some broken ones, some noise
   function automatic text_type random_text();
      text_type s;
      int    pick;
      int    pos;
      int    k;
      pick = $urandom_range(0, 99);
      if (pick < 70) return make_number();
      if (pick < 85) begin
         s   = make_number();
         pos = $urandom_range(0, s.size());
         case ($urandom_range(0, 3))
            0: s.insert(pos, char_type'($urandom_range(0, 255)));
            1: s.insert((pos == 0) ? 1 : pos, $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            2: begin
               s.push_back(CHAR_F);
               s.push_back(char_type'($urandom_range(0, 255)));
            end
            default: s.insert(pos, CHAR_DOT);
         endcase
         return s;
      end
      repeat ($urandom_range(1, 6)) begin
         k = $urandom_range(0, 17);
         if (k < 10) s.push_back(digit_char(k));
         else if (k < 14) s.push_back(MARKS[k-10]);
         else s.push_back(char_type'($urandom_range(0, 255)));
      end
      return s;
   endfunction

   task automatic test_directed();
      text_type s;
      s = {CHAR_MINUS, CHAR_NINE, CHAR_ZERO, CHAR_DOT, digit_char(5), CHAR_F};
      send_text(s);
      // anything after f breaks the string
      s = {digit_char(1), CHAR_F, digit_char(2)};
      send_text(s);
      // leading sign is fine, a later one is not
      s = {CHAR_PLUS, digit_char(1), CHAR_PLUS};
      send_text(s);
      s = {8'hFF, digit_char(3)};
      send_text(s);
      s = {8'h00};
      send_text(s);
      // run the place weight down to zero
      s = {CHAR_DOT};
      repeat (13) s.push_back(CHAR_ZERO);
      s.push_back(digit_char(1));
      s.push_back(CHAR_NINE);
      send_text(s);
      wait_for_results();
   endtask

   task automatic test_random(input int n);
      int stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) steady_send = !steady_send;
         if ($urandom_range(0, 9) == 0) steady_recv = !steady_recv;
         send_text(random_text());
      end
      steady_send = 1'b0;
      steady_recv = 1'b0;
      wait_for_results();
   endtask

   task automatic test_fraction_off();
      text_type s;
      write_fraction_enable(1'b0);
      s = {digit_char(3), CHAR_DOT, digit_char(2), digit_char(5)};
      send_text(s);
      test_random(400);
      write_fraction_enable(1'b1);
   endtask

   task automatic test_backpressure();
      hold_off_cycles = HOLD_OFF_CYCLES;
      steady_send     = 1'b1;
      repeat (12) send_text(make_number());
      steady_send = 1'b0;
      wait_for_results();
   endtask

   initial begin : result_receiver
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end else begin
            gap = steady_recv ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) && hold_off_cycles == 0);
      end
   end

   always @(posedge clock) begin : result_check
      number_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_numbers.size() == 0) begin
            report_mismatch("result transaction with no string pending");
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_ch.valid_res !== want.valid_res)
               report_mismatch($sformatf("valid_res %b, expected %b",
                                         rsp_ch.valid_res, want.valid_res));
            if (rsp_ch.int_value !== want.int_value)
               report_mismatch($sformatf("int_value %0d, expected %0d",
                                         rsp_ch.int_value, want.int_value));
            if (rsp_ch.frac_value !== want.frac_value)
               report_mismatch($sformatf("frac_value %h, expected %h",
                                         rsp_ch.frac_value, want.frac_value));
            if (rsp_ch.negative !== want.negative)
               report_mismatch($sformatf("negative %b, expected %b",
                                         rsp_ch.negative, want.negative));
         end
      end
   end

   // end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.char_code       = '0;
      req_ch.last            = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.fraction_enable = 1'b0;
      frac_on                = 1'b1;
      clear_number();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(900);
      test_fraction_off();
      test_backpressure();
      test_random(450);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
